@@ rtl/vft_pkg.sv @@
// ---------------------------------------------------------------------------
// vft_pkg
// Shared types and constants for the viewport fit transform block.
// ---------------------------------------------------------------------------
package vft_pkg;

	localparam int DISP_W    = 16;  // display box coordinates, whole pixels
	localparam int CFG_IDX_W = 2;
	localparam int PT_W      = 32;  // point coordinate width
	localparam int SCALE_W   = 32;
	localparam int SUM_W     = PT_W + 1;            // max + min of one axis
	localparam int XP_W      = DISP_W + PT_W;       // cross-multiply products
	localparam int NUM_W     = 2 * SCALE_W;         // dividend, display span shifted up
	localparam int PROD_W    = SUM_W + SCALE_W;     // |sum| * scale
	localparam int RES_W     = PROD_W + 1;          // signed translation before saturation
	localparam int IN_DATA_W = 2 * PT_W;
	localparam int OUT_DATA_W = SCALE_W + 2 * PT_W;
	localparam int DIV_STEPS = SCALE_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	localparam logic [DISP_W-1:0]  RST_LEFT   = 16'd0;
	localparam logic [DISP_W-1:0]  RST_BOTTOM = 16'd0;
	localparam logic [DISP_W-1:0]  RST_RIGHT  = 16'd639;
	localparam logic [DISP_W-1:0]  RST_TOP    = 16'd479;
	localparam logic [SCALE_W-1:0] SCALE_SAT  = {SCALE_W{1'b1}};
	localparam logic [PT_W-1:0]    SHIFT_MAX  = {1'b0, {(PT_W-1){1'b1}}};
	localparam logic [PT_W-1:0]    SHIFT_MIN  = {1'b1, {(PT_W-1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LEFT,
		CFG_BOTTOM,
		CFG_RIGHT,
		CFG_TOP
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SPAN,
		ST_MULA,
		ST_MULB,
		ST_DINIT,
		ST_DIV,
		ST_SCALE,
		ST_MULX,
		ST_ACCX,
		ST_FINX,
		ST_MULY,
		ST_ACCY,
		ST_FINY,
		ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_SPAN,
		OP_MULA,
		OP_MULB,
		OP_DINIT,
		OP_DSTEP,
		OP_SCALE,
		OP_MUL,
		OP_ACC,
		OP_FIN,
		OP_LOAD
	} op_t;

	typedef struct packed {
		logic take;     // point transfer this cycle
		op_t  op;
		logic axis_y;   // MUL/ACC/FIN work on the y axis
	} vft_cmd_t;

	typedef struct packed {
		logic div_last;  // final quotient bit in this step
		logic out_free;  // output register can take a result
	} vft_stat_t;

endpackage

@@ rtl/vft_ctrl.sv @@
// ---------------------------------------------------------------------------
// vft_ctrl
// Sequencer: accepts points, then steps the datapath through span, ratio
// selection, division, translation and result load.
// ---------------------------------------------------------------------------
module vft_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tlast,
	input  vft_pkg::vft_stat_t stat,
	output logic             s_tready,
	output vft_pkg::vft_cmd_t  cmd
);
	import vft_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid && s_tlast) state_d = ST_SPAN;
			end
			ST_SPAN:  state_d = ST_MULA;
			ST_MULA:  state_d = ST_MULB;
			ST_MULB:  state_d = ST_DINIT;
			ST_DINIT: state_d = ST_DIV;
			ST_DIV: begin
				if (stat.div_last) state_d = ST_SCALE;
			end
			ST_SCALE: state_d = ST_MULX;
			ST_MULX:  state_d = ST_ACCX;
			ST_ACCX:  state_d = ST_FINX;
			ST_FINX:  state_d = ST_MULY;
			ST_MULY:  state_d = ST_ACCY;
			ST_ACCY:  state_d = ST_FINY;
			ST_FINY:  state_d = ST_OUT;
			ST_OUT: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		cmd.take   = 1'b0;
		cmd.op     = OP_NONE;
		cmd.axis_y = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.take = s_tvalid;
			end
			ST_SPAN:  cmd.op = OP_SPAN;
			ST_MULA:  cmd.op = OP_MULA;
			ST_MULB:  cmd.op = OP_MULB;
			ST_DINIT: cmd.op = OP_DINIT;
			ST_DIV:   cmd.op = OP_DSTEP;
			ST_SCALE: cmd.op = OP_SCALE;
			ST_MULX:  cmd.op = OP_MUL;
			ST_ACCX:  cmd.op = OP_ACC;
			ST_FINX:  cmd.op = OP_FIN;
			ST_MULY: begin
				cmd.op     = OP_MUL;
				cmd.axis_y = 1'b1;
			end
			ST_ACCY: begin
				cmd.op     = OP_ACC;
				cmd.axis_y = 1'b1;
			end
			ST_FINY: begin
				cmd.op     = OP_FIN;
				cmd.axis_y = 1'b1;
			end
			ST_OUT: begin
				if (stat.out_free) cmd.op = OP_LOAD;
			end
			default: cmd.op = OP_NONE;
		endcase
	end

endmodule

@@ rtl/vft_dp.sv @@
// ---------------------------------------------------------------------------
// vft_dp
// Datapath: display registers, bounding box tracker, restoring divider for
// the scale, shared 32x32 multiplier for the translations, output register.
// ---------------------------------------------------------------------------
module vft_dp #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [vft_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [vft_pkg::DISP_W-1:0]        cfg_wdata,
	input  logic [vft_pkg::PT_W-1:0]          point_x,
	input  logic [vft_pkg::PT_W-1:0]          point_y,
	input  logic                              point_last,
	input  vft_pkg::vft_cmd_t                 cmd,
	output vft_pkg::vft_stat_t                stat,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [vft_pkg::SCALE_W-1:0]       scale_factor,
	output logic [vft_pkg::PT_W-1:0]          shift_x,
	output logic [vft_pkg::PT_W-1:0]          shift_y,
	output logic                              degenerate
);
	import vft_pkg::*;

	localparam int DC_W = DISP_W + FRAC_BITS;

	// configuration
	logic [DISP_W-1:0] left_q, bottom_q, right_q, top_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= RST_LEFT;
			bottom_q <= RST_BOTTOM;
			right_q  <= RST_RIGHT;
			top_q    <= RST_TOP;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_addr))
				CFG_LEFT:   left_q   <= cfg_wdata;
				CFG_BOTTOM: bottom_q <= cfg_wdata;
				CFG_RIGHT:  right_q  <= cfg_wdata;
				CFG_TOP:    top_q    <= cfg_wdata;
				default:    left_q   <= left_q;
			endcase
		end
	end

	// bounding box
	logic            first_q;
	logic [PT_W-1:0] min_x_q, max_x_q, min_y_q, max_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
		end else if (cmd.take) begin
			first_q <= point_last;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			if (first_q || $signed(point_x) < $signed(min_x_q)) min_x_q <= point_x;
			if (first_q || $signed(point_x) > $signed(max_x_q)) max_x_q <= point_x;
			if (first_q || $signed(point_y) < $signed(min_y_q)) min_y_q <= point_y;
			if (first_q || $signed(point_y) > $signed(max_y_q)) max_y_q <= point_y;
		end
	end

	// spans, sums and display centers
	logic [PT_W-1:0]   w_q, h_q;
	logic [DISP_W-1:0] dw_q, dh_q;
	logic [SUM_W-1:0]  sumx_q, sumy_q;
	logic [DC_W-1:0]   dcx_q, dcy_q;
	logic [XP_W-1:0]   cross_q;
	logic              use_x_q;
	logic [DISP_W:0]   dsum_x, dsum_y;

	assign dsum_x = (DISP_W+1)'(left_q) + (DISP_W+1)'(right_q);
	assign dsum_y = (DISP_W+1)'(bottom_q) + (DISP_W+1)'(top_q);

	// divider
	logic [SCALE_W-1:0] obj_q, rem_q, lo_q, quot_q, scale_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               sat_q, degen_q;
	logic [DISP_W-1:0]  div_disp;
	logic [SCALE_W-1:0] div_obj;
	logic [NUM_W-1:0]   div_num;
	logic [SCALE_W:0]   trial;
	logic               trial_ge;

	assign div_disp = use_x_q ? dw_q : dh_q;
	assign div_obj  = use_x_q ? w_q : h_q;
	assign div_num  = NUM_W'(div_disp) << (2 * FRAC_BITS);
	assign trial    = {rem_q, lo_q[SCALE_W-1]};
	assign trial_ge = trial >= {1'b0, obj_q};

	// translation
	logic [SUM_W-1:0]        sum_sel, mag;
	logic [2*SCALE_W-1:0]    pp_q;
	logic                    top_bit_q, neg_q;
	logic [PROD_W-1:0]       prod_q, prod_sh;
	logic                    rnz;
	logic signed [RES_W-1:0] qs, dcs, res;
	logic [PT_W-1:0]         res_sat;
	logic [PT_W-1:0]         shx_q, shy_q;

	assign sum_sel = cmd.axis_y ? sumy_q : sumx_q;
	assign mag     = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : sum_sel;
	assign prod_sh = prod_q >> (FRAC_BITS + 1);
	assign rnz     = |prod_q[FRAC_BITS:0];
	assign qs      = $signed(RES_W'(prod_sh));
	assign dcs     = $signed(RES_W'(cmd.axis_y ? dcy_q : dcx_q));
	assign res     = neg_q ? dcs + qs + RES_W'(rnz) : dcs - qs;

	always_comb begin
		if ((&res[RES_W-1:PT_W-1]) || !(|res[RES_W-1:PT_W-1])) begin
			res_sat = res[PT_W-1:0];
		end else if (res[RES_W-1]) begin
			res_sat = SHIFT_MIN;
		end else begin
			res_sat = SHIFT_MAX;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_SPAN: begin
				w_q     <= max_x_q - min_x_q;
				h_q     <= max_y_q - min_y_q;
				dw_q    <= (right_q > left_q) ? right_q - left_q : '0;
				dh_q    <= (top_q > bottom_q) ? top_q - bottom_q : '0;
				degen_q <= (max_x_q == min_x_q) && (max_y_q == min_y_q);
				sumx_q  <= {max_x_q[PT_W-1], max_x_q} + {min_x_q[PT_W-1], min_x_q};
				sumy_q  <= {max_y_q[PT_W-1], max_y_q} + {min_y_q[PT_W-1], min_y_q};
				dcx_q   <= DC_W'(dsum_x) << (FRAC_BITS - 1);
				dcy_q   <= DC_W'(dsum_y) << (FRAC_BITS - 1);
			end
			OP_MULA: cross_q <= XP_W'(dw_q) * XP_W'(h_q);
			OP_MULB: begin
				// take the x ratio when the width is the tighter fit
				use_x_q <= (w_q != '0) &&
				           ((h_q == '0) || (cross_q < XP_W'(dh_q) * XP_W'(w_q)));
			end
			OP_DINIT: begin
				obj_q  <= div_obj;
				rem_q  <= div_num[NUM_W-1:SCALE_W];
				lo_q   <= div_num[SCALE_W-1:0];
				// quotient of 2^32 or more, or a zero divisor: saturate
				sat_q  <= div_num[NUM_W-1:SCALE_W] >= div_obj;
				cnt_q  <= '0;
			end
			OP_DSTEP: begin
				rem_q  <= trial_ge ? SCALE_W'(trial - {1'b0, obj_q}) : SCALE_W'(trial);
				lo_q   <= lo_q << 1;
				quot_q <= {quot_q[SCALE_W-2:0], trial_ge};
				cnt_q  <= cnt_q + 1'b1;
			end
			OP_SCALE: scale_q <= sat_q ? SCALE_SAT : quot_q;
			OP_MUL: begin
				pp_q      <= (2*SCALE_W)'(mag[SCALE_W-1:0]) * (2*SCALE_W)'(scale_q);
				top_bit_q <= mag[SUM_W-1];
				// y is flipped, so its sign is inverted
				neg_q     <= sum_sel[SUM_W-1] ^ cmd.axis_y;
			end
			OP_ACC: begin
				prod_q <= PROD_W'(pp_q) +
				          {(top_bit_q ? {1'b0, scale_q} : {(SCALE_W+1){1'b0}}),
				           {SCALE_W{1'b0}}};
			end
			OP_FIN: begin
				if (cmd.axis_y) shy_q <= res_sat;
				else            shx_q <= res_sat;
			end
			default: cnt_q <= cnt_q;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.op == OP_LOAD) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) begin
			scale_factor <= scale_q;
			shift_x      <= shx_q;
			shift_y      <= shy_q;
			degenerate   <= degen_q;
		end
	end

	assign stat.div_last = cnt_q == CNT_W'(DIV_STEPS - 1);
	assign stat.out_free = !out_valid || out_ready;

endmodule

@@ rtl/viewport_fit_transform.sv @@
// ---------------------------------------------------------------------------
// viewport_fit_transform
// Fits the bounding box of a point stream into a display box and reports
// the uniform scale and the centering translation with y flipped.
// ---------------------------------------------------------------------------
// Points are taken one per cycle while the block is collecting; each
// transfer updates the running min/max box. The point marked with tlast
// closes the picture: input stalls while the result is computed and until the
// output register is free. The computation is dominated by the 32-step
// restoring divider that forms the scale one quotient bit per cycle; the two
// translations then share one 32x32 multiplier. The result waits in an output
// register, so points of the next picture are taken while it is still pending.
module viewport_fit_transform #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [vft_pkg::CFG_IDX_W-1:0]       cfg_addr,
	input  logic [vft_pkg::DISP_W-1:0]          cfg_wdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [vft_pkg::IN_DATA_W-1:0]       s_tdata,  // point_x, point_y
	input  logic                                s_tlast,  // last_point
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [vft_pkg::OUT_DATA_W-1:0]      m_tdata,  // scale_factor, shift_x, shift_y
	output logic [0:0]                          m_tuser   // degenerate
);
	import vft_pkg::*;

	vft_cmd_t  cmd;
	vft_stat_t stat;

	vft_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.stat     (stat),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	vft_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.point_x      (s_tdata[PT_W-1:0]),
		.point_y      (s_tdata[2*PT_W-1:PT_W]),
		.point_last   (s_tlast),
		.cmd          (cmd),
		.stat         (stat),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.scale_factor (m_tdata[SCALE_W-1:0]),
		.shift_x      (m_tdata[SCALE_W+PT_W-1:SCALE_W]),
		.shift_y      (m_tdata[SCALE_W+2*PT_W-1:SCALE_W+PT_W]),
		.degenerate   (m_tuser[0])
	);

endmodule

@@ rtl/vft_checker.sv @@
// ---------------------------------------------------------------------------
// vft_checker
// Port-level checks for viewport_fit_transform, bound to the top level.
// ---------------------------------------------------------------------------
module vft_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           s_tlast,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [vft_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic [0:0]                     m_tuser
);
	import vft_pkg::*;

	// a held result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// a zero-size box always reports the saturated scale
	a_degen_scale: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[SCALE_W-1:0] == SCALE_SAT)
		else $error("degenerate result without saturated scale");

	// closing a picture stops intake for the computation
	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready ##1 !s_tready)
		else $error("input accepted right after last point");

	// a new result is only loaded while intake is stalled
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without a computation");

endmodule

bind viewport_fit_transform vft_checker u_vft_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
